### rtl/core/fdr_pkg.sv
// fdr_pkg: widths, pipeline word type and per-stage functions for the
// dielectric Fresnel reflectance core. No dependencies.
`default_nettype none
package fdr_pkg;

    localparam int unsigned COS_W  = 16;
    localparam int unsigned ETA_W  = 16;
    localparam int unsigned REFL_W = 16;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // stage map
    localparam int unsigned ST_SWAP  = 0;
    localparam int unsigned ST_RADA  = 1;
    localparam int unsigned SQ_STEPS = 16;
    localparam int unsigned ST_SQA   = 2;
    localparam int unsigned ST_PROD  = ST_SQA + SQ_STEPS;
    localparam int unsigned DV_STEPS = 15;
    localparam int unsigned ST_DIV   = ST_PROD + 1;
    localparam int unsigned ST_RADB  = ST_DIV + DV_STEPS;
    localparam int unsigned ST_SQB   = ST_RADB + 1;
    localparam int unsigned ST_MUL   = ST_SQB + SQ_STEPS;
    localparam int unsigned ST_DIFF  = ST_MUL + 1;
    localparam int unsigned RD_STEPS = 31;
    localparam int unsigned ST_RDIV  = ST_DIFF + 1;
    localparam int unsigned ST_SQR   = ST_RDIV + RD_STEPS;
    localparam int unsigned ST_OUT   = ST_SQR + 1;
    localparam int unsigned NSTG     = ST_OUT + 1;

    typedef struct packed {
        logic [16:0] c;       // |cos| Q15, up to one
        logic [15:0] ni;
        logic [15:0] nt;
        logic        tir;
        logic [31:0] sv;      // sqrt radicand, consumed two bits a step
        logic [17:0] srem;
        logic [15:0] root;
        logic [31:0] p;       // ni * sin_i
        logic [17:0] dr;
        logic [14:0] q;       // sin_t
        logic [31:0] a1, b1, a2, b2;
        logic [33:0] den1, den2;
        logic [33:0] rem1, rem2;
        logic [30:0] r1, r2;
        logic        z1, z2;
        logic [60:0] sq1, sq2;
        logic [15:0] refl;
    } t_pipe;

    function automatic t_pipe f_swap(logic [15:0] raw, logic [15:0] ei, logic [15:0] et);
        t_pipe y;
        logic  neg;
        y   = '0;
        neg = raw[15];
        if (raw != '0 && !neg) begin
            y.ni = ei;
            y.nt = et;
        end else begin
            y.ni = et;
            y.nt = ei;
        end
        y.c = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        return y;
    endfunction

    function automatic t_pipe f_rad_a(t_pipe x);
        t_pipe       y;
        logic [33:0] cc;
        y      = x;
        cc     = 34'(x.c) * 34'(x.c);
        y.sv   = ONE_Q30 - cc[31:0];
        y.srem = '0;
        y.root = '0;
        return y;
    endfunction

    function automatic t_pipe f_sq_step(t_pipe x);
        t_pipe       y;
        logic [19:0] rm;
        logic [19:0] tr;
        y  = x;
        rm = {x.srem, x.sv[31:30]};
        tr = {2'b00, x.root, 2'b01};
        if (rm >= tr) begin
            y.srem = 18'(rm - tr);
            y.root = {x.root[14:0], 1'b1};
        end else begin
            y.srem = rm[17:0];
            y.root = {x.root[14:0], 1'b0};
        end
        y.sv = {x.sv[29:0], 2'b00};
        return y;
    endfunction

    function automatic t_pipe f_prod(t_pipe x);
        t_pipe y;
        y     = x;
        y.p   = 32'(x.ni) * 32'(x.root);
        y.tir = (y.p >= {1'b0, x.nt, 15'b0});
        y.dr  = {1'b0, y.p[31:15]};
        y.q   = '0;
        return y;
    endfunction

    function automatic t_pipe f_div_step(t_pipe x, logic [4:0] idx);
        t_pipe       y;
        logic [17:0] r;
        y = x;
        r = {x.dr[16:0], x.p[idx]};
        if (r >= {2'b00, x.nt}) begin
            y.dr = r - {2'b00, x.nt};
            y.q  = {x.q[13:0], 1'b1};
        end else begin
            y.dr = r;
            y.q  = {x.q[13:0], 1'b0};
        end
        return y;
    endfunction

    function automatic t_pipe f_rad_b(t_pipe x);
        t_pipe       y;
        logic [29:0] ss;
        y      = x;
        ss     = 30'(x.q) * 30'(x.q);
        y.sv   = ONE_Q30 - {2'b00, ss};
        y.srem = '0;
        y.root = '0;
        return y;
    endfunction

    function automatic t_pipe f_mul(t_pipe x);
        t_pipe y;
        y    = x;
        y.a1 = 32'(x.nt) * 32'(x.c);
        y.b1 = 32'(x.ni) * 32'(x.root);
        y.a2 = 32'(x.ni) * 32'(x.c);
        y.b2 = 32'(x.nt) * 32'(x.root);
        return y;
    endfunction

    function automatic t_pipe f_diff(t_pipe x);
        t_pipe y;
        y      = x;
        y.den1 = 34'(x.a1) + 34'(x.b1);
        y.den2 = 34'(x.a2) + 34'(x.b2);
        y.rem1 = 34'((x.a1 >= x.b1) ? (x.a1 - x.b1) : (x.b1 - x.a1));
        y.rem2 = 34'((x.a2 >= x.b2) ? (x.a2 - x.b2) : (x.b2 - x.a2));
        y.z1   = (y.den1 == '0);
        y.z2   = (y.den2 == '0);
        y.r1   = '0;
        y.r2   = '0;
        return y;
    endfunction

    function automatic t_pipe f_rdiv_step(t_pipe x, logic first);
        t_pipe       y;
        logic [33:0] t1, t2;
        y  = x;
        t1 = first ? x.rem1 : {x.rem1[32:0], 1'b0};
        t2 = first ? x.rem2 : {x.rem2[32:0], 1'b0};
        if (t1 >= x.den1) begin
            y.rem1 = t1 - x.den1;
            y.r1   = {x.r1[29:0], 1'b1};
        end else begin
            y.rem1 = t1;
            y.r1   = {x.r1[29:0], 1'b0};
        end
        if (t2 >= x.den2) begin
            y.rem2 = t2 - x.den2;
            y.r2   = {x.r2[29:0], 1'b1};
        end else begin
            y.rem2 = t2;
            y.r2   = {x.r2[29:0], 1'b0};
        end
        return y;
    endfunction

    function automatic t_pipe f_sqr(t_pipe x);
        t_pipe       y;
        logic [61:0] m1, m2;
        y     = x;
        m1    = 62'(x.r1) * 62'(x.r1);
        m2    = 62'(x.r2) * 62'(x.r2);
        y.sq1 = x.z1 ? (61'(1) << 60) : m1[60:0];
        y.sq2 = x.z2 ? (61'(1) << 60) : m2[60:0];
        return y;
    endfunction

    function automatic t_pipe f_out(t_pipe x);
        t_pipe       y;
        logic [61:0] s;
        logic [15:0] rf;
        y  = x;
        s  = 62'(x.sq1) + 62'(x.sq2) + (62'(1) << 45);
        rf = s[61:46];
        if (x.tir || rf > ONE_Q15) begin
            y.refl = ONE_Q15;
        end else begin
            y.refl = rf;
        end
        return y;
    endfunction

endpackage
`default_nettype wire

### rtl/core/fdr_ifs.sv
// fdr_in_if / fdr_out_if: valid-ready channels of the reflectance core.
// Depends on fdr_pkg for field widths.
`default_nettype none
interface fdr_in_if;
    import fdr_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [COS_W-1:0] cos_incident;
    logic [ETA_W-1:0]        eta_incident;
    logic [ETA_W-1:0]        eta_transmitted;
    modport source (output valid, cos_incident, eta_incident, eta_transmitted, input ready);
    modport sink   (input valid, cos_incident, eta_incident, eta_transmitted, output ready);
endinterface

interface fdr_out_if;
    import fdr_pkg::*;
    logic              valid;
    logic              ready;
    logic [REFL_W-1:0] reflectance;
    logic              total_internal;
    modport source (output valid, reflectance, total_internal, input ready);
    modport sink   (input valid, reflectance, total_internal, output ready);
endinterface
`default_nettype wire

### rtl/core/fresnel_dielectric_reflectance_core.sv
// Unpolarized dielectric Fresnel reflectance, 86-stage pipeline. Takes one
// word per cycle while the output is drained and returns one word per input,
// in order. The stage count is set by the two 16-step square roots, the
// 15-step Snell divide and the 31-step ratio divides, each one bit per
// stage. The whole pipe holds while the output word is not taken.
// Depends on fdr_pkg and fdr_ifs.
`default_nettype none
module fresnel_dielectric_reflectance_core
    import fdr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    fdr_in_if.sink     i_in,
    fdr_out_if.source  o_out
);

    t_pipe r_stg [NSTG];
    t_pipe n_stg [NSTG];
    logic  [NSTG-1:0] r_vld;
    logic  en;

    assign en         = !r_vld[NSTG-1] || o_out.ready;
    assign i_in.ready = en;

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_stg
            if (g == ST_SWAP) begin : g_sw
                assign n_stg[g] = f_swap(i_in.cos_incident, i_in.eta_incident,
                                         i_in.eta_transmitted);
            end else if (g == ST_RADA) begin : g_ra
                assign n_stg[g] = f_rad_a(r_stg[g-1]);
            end else if (g >= ST_SQA && g < ST_PROD) begin : g_sa
                assign n_stg[g] = f_sq_step(r_stg[g-1]);
            end else if (g == ST_PROD) begin : g_pr
                assign n_stg[g] = f_prod(r_stg[g-1]);
            end else if (g >= ST_DIV && g < ST_RADB) begin : g_dv
                assign n_stg[g] = f_div_step(r_stg[g-1],
                                             5'(DV_STEPS - 1 - (g - ST_DIV)));
            end else if (g == ST_RADB) begin : g_rb
                assign n_stg[g] = f_rad_b(r_stg[g-1]);
            end else if (g >= ST_SQB && g < ST_MUL) begin : g_sb
                assign n_stg[g] = f_sq_step(r_stg[g-1]);
            end else if (g == ST_MUL) begin : g_mu
                assign n_stg[g] = f_mul(r_stg[g-1]);
            end else if (g == ST_DIFF) begin : g_df
                assign n_stg[g] = f_diff(r_stg[g-1]);
            end else if (g >= ST_RDIV && g < ST_SQR) begin : g_rd
                assign n_stg[g] = f_rdiv_step(r_stg[g-1], 1'(g == ST_RDIV));
            end else if (g == ST_SQR) begin : g_sq
                assign n_stg[g] = f_sqr(r_stg[g-1]);
            end else begin : g_ot
                assign n_stg[g] = f_out(r_stg[g-1]);
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_stg[g] <= n_stg[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in.valid};
        end
    end

    assign o_out.valid          = r_vld[NSTG-1];
    assign o_out.reflectance    = r_stg[NSTG-1].refl;
    assign o_out.total_internal = r_stg[NSTG-1].tir;

endmodule
`default_nettype wire
